@@ hw/rtl/wsfr_pkg.sv @@
package wsfr_pkg;

    // Parse phase of the frame header walker
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } phase_t;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Result channels
    localparam logic [1:0] CH_MESSAGE = 2'd0;
    localparam logic [1:0] CH_PING    = 2'd1;
    localparam logic [1:0] CH_CLOSE   = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // One classified beat between the parser and the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       byte_valid;
        logic [1:0] channel;
        logic       is_binary;
        logic       message_end;
        logic       ping_end;
    } entry_t;

endpackage

@@ hw/rtl/wsfr_front.sv @@
module wsfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              queue_full,
    output logic              push,
    output wsfr_pkg::entry_t  push_entry
);

    wsfr_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        final_reg, final_next;
    logic        masked_reg, masked_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [2:0]  hdr_count_reg, hdr_count_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_phase_reg, key_phase_next;
    logic        msg_open_reg, msg_open_next;
    logic        msg_binary_reg, msg_binary_next;

    logic        accept;
    logic        kind_data;
    logic        kind_ping;
    logic        emit;
    logic        emit_valid;
    logic        emit_last;
    logic        close_beat;
    logic [7:0]  key_byte;
    logic [6:0]  len7;
    logic [63:0] ext_length;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign len7     = rx_byte[6:0];
    assign ext_length = {remaining_reg[55:0], rx_byte};

    assign kind_data = (opcode_reg == wsfr_pkg::OP_TEXT) || (opcode_reg == wsfr_pkg::OP_BINARY)
                       || ((opcode_reg == wsfr_pkg::OP_CONT) && msg_open_reg);
    assign kind_ping = (opcode_reg == wsfr_pkg::OP_PING);

    always_comb
    begin
        unique case (key_phase_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        final_next      = final_reg;
        masked_next     = masked_reg;
        remaining_next  = remaining_reg;
        hdr_count_next  = hdr_count_reg;
        key_next        = key_reg;
        key_phase_next  = key_phase_reg;
        msg_open_next   = msg_open_reg;
        msg_binary_next = msg_binary_reg;
        emit            = 1'b0;
        emit_valid      = 1'b0;
        emit_last       = 1'b0;
        close_beat      = 1'b0;

        unique case (phase_reg)
            wsfr_pkg::PH_HDR0:
            begin
                final_next  = rx_byte[7];
                opcode_next = rx_byte[3:0];
                if (rx_byte[3:0] == wsfr_pkg::OP_TEXT || rx_byte[3:0] == wsfr_pkg::OP_BINARY)
                begin
                    msg_open_next   = 1'b1;
                    msg_binary_next = (rx_byte[3:0] == wsfr_pkg::OP_BINARY);
                end
                phase_next = wsfr_pkg::PH_HDR1;
            end
            wsfr_pkg::PH_HDR1:
            begin
                if (opcode_reg == wsfr_pkg::OP_CLOSE)
                begin
                    close_beat = 1'b1;
                    phase_next = wsfr_pkg::PH_CLOSED;
                end
                else
                begin
                    masked_next    = rx_byte[7];
                    key_next       = '0;
                    key_phase_next = '0;
                    remaining_next = '0;
                    if (len7 == wsfr_pkg::LEN_EXT16)
                    begin
                        hdr_count_next = 3'd1;
                        phase_next     = wsfr_pkg::PH_EXTLEN;
                    end
                    else if (len7 == wsfr_pkg::LEN_EXT64)
                    begin
                        hdr_count_next = 3'd7;
                        phase_next     = wsfr_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = {57'd0, len7};
                        if (rx_byte[7])
                        begin
                            hdr_count_next = 3'd3;
                            phase_next     = wsfr_pkg::PH_MASK;
                        end
                        else if (len7 == 7'd0)
                        begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            phase_next = wsfr_pkg::PH_HDR0;
                        end
                        else
                        begin
                            phase_next = wsfr_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            wsfr_pkg::PH_EXTLEN:
            begin
                remaining_next = ext_length;
                if (hdr_count_reg == 3'd0)
                begin
                    if (masked_reg)
                    begin
                        hdr_count_next = 3'd3;
                        phase_next     = wsfr_pkg::PH_MASK;
                    end
                    else if (ext_length == 64'd0)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = wsfr_pkg::PH_HDR0;
                    end
                    else
                    begin
                        phase_next = wsfr_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    hdr_count_next = hdr_count_reg - 3'd1;
                end
            end
            wsfr_pkg::PH_MASK:
            begin
                key_next = {key_reg[23:0], rx_byte};
                if (hdr_count_reg == 3'd0)
                begin
                    if (remaining_reg == 64'd0)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = wsfr_pkg::PH_HDR0;
                    end
                    else
                    begin
                        phase_next = wsfr_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    hdr_count_next = hdr_count_reg - 3'd1;
                end
            end
            wsfr_pkg::PH_PAYLOAD:
            begin
                key_phase_next = key_phase_reg + 2'd1;
                remaining_next = remaining_reg - 64'd1;
                emit           = 1'b1;
                emit_valid     = 1'b1;
                emit_last      = (remaining_reg == 64'd1);
                if (emit_last)
                begin
                    phase_next = wsfr_pkg::PH_HDR0;
                end
            end
            default:
            begin
                // closed: drop every byte until reset
            end
        endcase

        // a finished data frame with FIN closes the message
        if (emit && kind_data && emit_last && final_reg)
        begin
            msg_open_next = 1'b0;
        end
    end

    always_comb
    begin
        push_entry             = '0;
        push_entry.data        = rx_byte;
        push_entry.key         = masked_reg ? key_byte : 8'd0;
        push_entry.byte_valid  = emit_valid;
        if (close_beat)
        begin
            push_entry.channel    = wsfr_pkg::CH_CLOSE;
            push_entry.byte_valid = 1'b0;
        end
        else if (kind_data)
        begin
            push_entry.channel     = wsfr_pkg::CH_MESSAGE;
            push_entry.is_binary   = msg_binary_reg;
            push_entry.message_end = emit_last && final_reg;
        end
        else
        begin
            push_entry.channel  = wsfr_pkg::CH_PING;
            push_entry.ping_end = emit_last;
        end
    end

    assign push = accept && (close_beat || (emit && (kind_data || kind_ping)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wsfr_pkg::PH_HDR0;
            opcode_reg     <= '0;
            final_reg      <= 1'b0;
            masked_reg     <= 1'b0;
            remaining_reg  <= '0;
            hdr_count_reg  <= '0;
            key_reg        <= '0;
            key_phase_reg  <= '0;
            msg_open_reg   <= 1'b0;
            msg_binary_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            final_reg      <= final_next;
            masked_reg     <= masked_next;
            remaining_reg  <= remaining_next;
            hdr_count_reg  <= hdr_count_next;
            key_reg        <= key_next;
            key_phase_reg  <= key_phase_next;
            msg_open_reg   <= msg_open_next;
            msg_binary_reg <= msg_binary_next;
        end
    end

endmodule

@@ hw/rtl/wsfr_queue.sv @@
module wsfr_queue #(
    parameter int DEPTH = wsfr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfr_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output wsfr_pkg::entry_t  head_entry
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    wsfr_pkg::entry_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/wsfr_back.sv @@
module wsfr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  wsfr_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        payload_byte,
    output logic              byte_valid,
    output logic [1:0]        channel,
    output logic              is_binary,
    output logic              message_end,
    output logic              ping_end
);

    logic       valid_reg;
    logic [7:0] payload_reg, payload_next;
    logic       byte_valid_reg;
    logic [1:0] channel_reg;
    logic       is_binary_reg;
    logic       message_end_reg;
    logic       ping_end_reg;

    // advance when the output register is empty or being drained
    assign pop = head_valid && (!valid_reg || out_ready);

    // unmask payload beats; markers carry a zero byte
    assign payload_next = head_entry.byte_valid ? (head_entry.data ^ head_entry.key) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            payload_reg     <= payload_next;
            byte_valid_reg  <= head_entry.byte_valid;
            channel_reg     <= head_entry.channel;
            is_binary_reg   <= head_entry.is_binary;
            message_end_reg <= head_entry.message_end;
            ping_end_reg    <= head_entry.ping_end;
        end
    end

    assign out_valid    = valid_reg;
    assign payload_byte = payload_reg;
    assign byte_valid   = byte_valid_reg;
    assign channel      = channel_reg;
    assign is_binary    = is_binary_reg;
    assign message_end  = message_end_reg;
    assign ping_end     = ping_end_reg;

endmodule

@@ hw/rtl/websocket_frame_receiver.sv @@
// WebSocket frame receiver: takes one stream byte per cycle on the input channel while
// the queue is not full and emits unmasked payload beats tagged as message data (text or
// binary) or ping payload, one empty-frame marker per zero-length data or ping frame, and
// one close beat when a close frame arrives, after which all further bytes are taken and
// dropped until reset. Every byte passes through the header parser; a beat then passes
// through a queue of QUEUE_DEPTH entries and an output register, so the input keeps taking
// one byte per cycle while the output is stalled until the queue fills. Pong frames, stray
// continuations and unknown opcodes are consumed without output.
module websocket_frame_receiver #(
    parameter int QUEUE_DEPTH = wsfr_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic [1:0] channel,
    output logic       is_binary,
    output logic       message_end,
    output logic       ping_end
);

    logic             push;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    wsfr_pkg::entry_t push_entry;
    wsfr_pkg::entry_t head_entry;

    wsfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    wsfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .channel      (channel),
        .is_binary    (is_binary),
        .message_end  (message_end),
        .ping_end     (ping_end)
    );

endmodule
